// ===== rtl/mbpdu_pkg.sv =====
package mbpdu_pkg;

	// Request item kinds
	localparam logic [1:0] OP_REQ_BYTE  = 2'd0;
	localparam logic [1:0] OP_LOAD_IREG = 2'd1;
	localparam logic [1:0] OP_LOAD_DISC = 2'd2;

	// Function codes
	localparam logic [7:0] FC_READ_COILS  = 8'h01;
	localparam logic [7:0] FC_READ_DISC   = 8'h02;
	localparam logic [7:0] FC_READ_HOLD   = 8'h03;
	localparam logic [7:0] FC_READ_INPUT  = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FC_WRITE_REG   = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS  = 8'h10;

	// Exception codes (none means a normal reply)
	localparam logic [7:0] EXC_NONE       = 8'h00;
	localparam logic [7:0] EXC_ILLEGAL_FC = 8'h01;
	localparam logic [7:0] EXC_BAD_ADDR   = 8'h02;
	localparam logic [7:0] EXC_BAD_VALUE  = 8'h03;
	localparam logic [7:0] EXC_FLAG       = 8'h80;

	// Single coil values
	localparam logic [15:0] COIL_ON  = 16'hFF00;
	localparam logic [15:0] COIL_OFF = 16'h0000;

	// Configuration register indexes and limits
	localparam logic [1:0] CFG_MAX_READ_BITS   = 2'd0;
	localparam logic [1:0] CFG_MAX_READ_WORDS  = 2'd1;
	localparam logic [1:0] CFG_MAX_WRITE_BITS  = 2'd2;
	localparam logic [1:0] CFG_MAX_WRITE_WORDS = 2'd3;
	localparam logic [10:0] LIM_READ_BITS   = 11'd2000;
	localparam logic [6:0]  LIM_READ_WORDS  = 7'd125;
	localparam logic [10:0] LIM_WRITE_BITS  = 11'd1968;
	localparam logic [6:0]  LIM_WRITE_WORDS = 7'd123;

	// Request body layout and position limit
	localparam logic [8:0] DATA_OFFSET = 9'd6;
	localparam logic [8:0] POS_MAX     = 9'd511;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  pdu_byte;
		logic        last_byte;
		logic [15:0] load_address;
		logic [15:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] reply_bytes;
		logic [2:0]  valid_count;
		logic        is_exception;
		logic        reply_last;
	} out_item_t;

endpackage

// ===== rtl/modbus_pdu_server_top.sv =====
// Request and load transactions are taken one per cycle while no reply is being served.
// After the last request byte the block checks the request; a valid multiple write then
// writes each bit or register, then the header bytes are sent, followed by the packed bits
// of a bit read or the register bytes of a register read; each table memory access sets this pace.
// Reset clears control at once, then clears all tables in one pass over the largest table,
// during which no transaction is accepted.
module modbus_pdu_server_top #(
	parameter int COIL_COUNT      = 1024,
	parameter int DISCRETE_COUNT  = 1024,
	parameter int HOLDING_COUNT   = 1024,
	parameter int INPUT_REG_COUNT = 1024,
	parameter int STAGE_DEPTH     = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbpdu_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mbpdu_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [10:0]          cfg_data
);
	import mbpdu_pkg::*;

	localparam int CW = $clog2(COIL_COUNT);
	localparam int DW = $clog2(DISCRETE_COUNT);
	localparam int HW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
	localparam int IW = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
	localparam int SW = $clog2(STAGE_DEPTH);
	localparam int MAX_AB = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
	localparam int MAX_CD = (HOLDING_COUNT > INPUT_REG_COUNT) ? HOLDING_COUNT : INPUT_REG_COUNT;
	localparam int MAXC = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
	localparam logic [16:0] COIL_N  = 17'(COIL_COUNT);
	localparam logic [16:0] DISC_N  = 17'(DISCRETE_COUNT);
	localparam logic [16:0] HOLD_N  = 17'(HOLDING_COUNT);
	localparam logic [16:0] INPUT_N = 17'(INPUT_REG_COUNT);
	localparam logic [16:0] STAGE_N = 17'(STAGE_DEPTH);
	localparam logic [16:0] CLR_END = 17'(MAXC - 1);

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_CHECK   = 14'b00000000000100,
		S_HDR     = 14'b00000000001000,
		S_RB_REQ  = 14'b00000000010000,
		S_RB_BIT  = 14'b00000000100000,
		S_RB_PUSH = 14'b00000001000000,
		S_RW_REQ  = 14'b00000010000000,
		S_RW_HI   = 14'b00000100000000,
		S_RW_LO   = 14'b00001000000000,
		S_WC_REQ  = 14'b00010000000000,
		S_WC_BIT  = 14'b00100000000000,
		S_WW_REQ  = 14'b01000000000000,
		S_WW_DATA = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Configuration limits
	logic [10:0] max_rb_q, max_wb_q;
	logic [6:0]  max_rw_q, max_ww_q;

	// Request parse registers
	logic [8:0]  pos_q, tot_q;
	logic [7:0]  fc_q, pend_q, dbc_q;
	logic [15:0] addr_q, qv_q;

	// Serve registers
	logic [7:0]  code_q;
	logic [2:0]  hidx_q;
	logic [10:0] i_q;
	logic [7:0]  byte_q;
	logic [16:0] clr_q;

	// Reply packer and output register
	logic [31:0] acc_q;
	logic [1:0]  cnt_q;
	logic        out_valid_q;
	out_item_t   out_q;

	// Memories
	logic        coil_mem [COIL_COUNT];
	logic        disc_mem [DISCRETE_COUNT];
	logic [15:0] hold_mem [HOLDING_COUNT];
	logic [15:0] inp_mem  [INPUT_REG_COUNT];
	logic [15:0] stg_mem  [STAGE_DEPTH];
	logic        coil_rd_q, disc_rd_q;
	logic [15:0] hold_rd_q, inp_rd_q, stg_rd_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rb_q <= LIM_READ_BITS;
			max_rw_q <= LIM_READ_WORDS;
			max_wb_q <= LIM_WRITE_BITS;
			max_ww_q <= LIM_WRITE_WORDS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_READ_BITS:   max_rb_q <= cfg_data;
				CFG_MAX_READ_WORDS:  max_rw_q <= cfg_data[6:0];
				CFG_MAX_WRITE_BITS:  max_wb_q <= cfg_data;
				CFG_MAX_WRITE_WORDS: max_ww_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Input decode
	logic        in_acc, req_acc, last_acc;
	logic [8:0]  p_jpos, tot_nxt;
	logic [7:0]  stg_w;
	logic [SW-1:0] stg_wa;
	logic        stg_we;
	logic [15:0] stg_wdata;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign req_acc  = in_acc && (in_data.opcode == OP_REQ_BYTE);
	assign last_acc = req_acc && in_data.last_byte;
	assign p_jpos   = pos_q - DATA_OFFSET;
	assign stg_w    = p_jpos[8:1];
	assign stg_wa   = stg_w[SW-1:0];
	assign tot_nxt  = (pos_q < POS_MAX) ? pos_q + 9'd1 : POS_MAX;
	assign stg_we   = req_acc && (pos_q >= DATA_OFFSET) && (pos_q < POS_MAX) && p_jpos[0]
		&& ({9'b0, stg_w} < STAGE_N);
	assign stg_wdata = {pend_q, in_data.pdu_byte};

	// Request checks
	logic        is_multi, fc_known, is_rd_bits, is_rd_words, is_echo;
	logic [8:0]  rcv, body;
	logic [10:0] lim_rb, lim_wb;
	logic [6:0]  lim_rw, lim_ww;
	logic [16:0] sum_aq, sum_a1, need, q2, rd_size;
	logic        qz;
	logic [7:0]  code_c;

	assign is_multi   = (fc_q == FC_WRITE_COILS) || (fc_q == FC_WRITE_REGS);
	assign fc_known   = is_multi || ((fc_q >= FC_READ_COILS) && (fc_q <= FC_WRITE_REG));
	assign is_rd_bits = (fc_q == FC_READ_COILS) || (fc_q == FC_READ_DISC);
	assign is_rd_words = (fc_q == FC_READ_HOLD) || (fc_q == FC_READ_INPUT);
	assign is_echo    = !is_rd_bits && !is_rd_words;
	assign rcv     = (tot_q > DATA_OFFSET) ? tot_q - DATA_OFFSET : 9'd0;
	assign body    = tot_q - 9'd1;
	assign lim_rb  = (max_rb_q > LIM_READ_BITS) ? LIM_READ_BITS : max_rb_q;
	assign lim_rw  = (max_rw_q > LIM_READ_WORDS) ? LIM_READ_WORDS : max_rw_q;
	assign lim_wb  = (max_wb_q > LIM_WRITE_BITS) ? LIM_WRITE_BITS : max_wb_q;
	assign lim_ww  = (max_ww_q > LIM_WRITE_WORDS) ? LIM_WRITE_WORDS : max_ww_q;
	assign sum_aq  = {1'b0, addr_q} + {1'b0, qv_q};
	assign sum_a1  = {1'b0, addr_q} + 17'd1;
	assign need    = ({1'b0, qv_q} + 17'd7) >> 3;
	assign q2      = {qv_q, 1'b0};
	assign qz      = (qv_q == 16'd0);
	assign rd_size = (fc_q == FC_READ_COILS) ? COIL_N :
		(fc_q == FC_READ_DISC) ? DISC_N :
		(fc_q == FC_READ_HOLD) ? HOLD_N : INPUT_N;

	always_comb begin
		code_c = EXC_NONE;
		if (!fc_known) begin
			code_c = EXC_ILLEGAL_FC;
		end else if (body < (is_multi ? 9'd5 : 9'd4)) begin
			code_c = EXC_BAD_VALUE;
		end else begin
			case (fc_q)
				FC_READ_COILS, FC_READ_DISC: begin
					if (qz || qv_q > {5'b0, lim_rb}) code_c = EXC_BAD_VALUE;
					else if (sum_aq > rd_size) code_c = EXC_BAD_ADDR;
				end
				FC_READ_HOLD, FC_READ_INPUT: begin
					if (qz || qv_q > {9'b0, lim_rw}) code_c = EXC_BAD_VALUE;
					else if (sum_aq > rd_size) code_c = EXC_BAD_ADDR;
				end
				FC_WRITE_COIL: begin
					if (qv_q != COIL_OFF && qv_q != COIL_ON) code_c = EXC_BAD_VALUE;
					else if (sum_a1 > COIL_N) code_c = EXC_BAD_ADDR;
				end
				FC_WRITE_REG: begin
					if (sum_a1 > HOLD_N) code_c = EXC_BAD_ADDR;
				end
				FC_WRITE_COILS: begin
					if (qz || qv_q > {5'b0, lim_wb}) code_c = EXC_BAD_VALUE;
					else if (dbc_q != need[7:0]) code_c = EXC_BAD_VALUE;
					else if ({8'b0, rcv} < need) code_c = EXC_BAD_VALUE;
					else if (sum_aq > COIL_N) code_c = EXC_BAD_ADDR;
				end
				default: begin
					if (qz || qv_q > {9'b0, lim_ww}) code_c = EXC_BAD_VALUE;
					else if (dbc_q != q2[7:0]) code_c = EXC_BAD_VALUE;
					else if ({8'b0, rcv} < q2) code_c = EXC_BAD_VALUE;
					else if (sum_aq > HOLD_N) code_c = EXC_BAD_ADDR;
				end
			endcase
		end
	end

	// Serve datapath
	logic        exc;
	logic [7:0]  hdr_byte;
	logic [2:0]  hdr_last;
	logic [16:0] tbl_addr;
	logic [16:0] i_ext, i_nxt;
	logic        i_done, rb_bit;
	logic [15:0] rd_word;
	logic [7:0]  wc_j, wc_byte;
	logic        wc_bit;
	logic [15:0] stg_ridx;

	assign exc      = (code_q != EXC_NONE);
	assign hdr_last = (exc || !is_echo) ? 3'd1 : 3'd4;
	assign i_ext    = {6'b0, i_q};
	assign i_nxt    = i_ext + 17'd1;
	assign i_done   = (i_nxt == {1'b0, qv_q});
	assign tbl_addr = {1'b0, addr_q} + i_ext;
	assign rb_bit   = (fc_q == FC_READ_COILS) ? coil_rd_q : disc_rd_q;
	assign rd_word  = (fc_q == FC_READ_HOLD) ? hold_rd_q : inp_rd_q;
	assign wc_j     = i_q[10:3];
	assign wc_byte  = (!wc_j[0] && ({1'b0, wc_j} + 9'd1 == rcv)) ? pend_q :
		(wc_j[0] ? stg_rd_q[7:0] : stg_rd_q[15:8]);
	assign wc_bit   = wc_byte[i_q[2:0]];
	assign stg_ridx = (state_q == S_WW_REQ || state_q == S_WW_DATA) ?
		{5'b0, i_q} : {9'b0, i_q[10:4]};

	always_comb begin
		case (hidx_q)
			3'd0: hdr_byte = exc ? (fc_q | EXC_FLAG) : fc_q;
			3'd1: hdr_byte = exc ? code_q : is_rd_bits ? need[7:0] :
				is_rd_words ? q2[7:0] : addr_q[15:8];
			3'd2: hdr_byte = addr_q[7:0];
			3'd3: hdr_byte = qv_q[15:8];
			default: hdr_byte = qv_q[7:0];
		endcase
	end

	// Select the byte pushed into the packer
	logic       out_free, push_en, push_fin, emit;
	logic [7:0] push_b;
	logic [31:0] acc_nxt;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		push_en  = 1'b0;
		push_b   = 8'd0;
		push_fin = 1'b0;
		case (state_q)
			S_HDR: begin
				push_en  = out_free;
				push_b   = hdr_byte;
				push_fin = (hidx_q == hdr_last) && (exc || is_echo);
			end
			S_RB_PUSH: begin
				push_en  = out_free;
				push_b   = byte_q;
				push_fin = (i_ext == {1'b0, qv_q});
			end
			S_RW_HI: begin
				push_en = out_free;
				push_b  = rd_word[15:8];
			end
			S_RW_LO: begin
				push_en  = out_free;
				push_b   = rd_word[7:0];
				push_fin = i_done;
			end
			default: ;
		endcase
	end

	assign emit = push_fin || (cnt_q == 2'd3);

	always_comb begin
		case (cnt_q)
			2'd0: acc_nxt = acc_q | {push_b, 24'b0};
			2'd1: acc_nxt = acc_q | {8'b0, push_b, 16'b0};
			2'd2: acc_nxt = acc_q | {16'b0, push_b, 8'b0};
			default: acc_nxt = acc_q | {24'b0, push_b};
		endcase
	end

	// Pack bytes and hold the output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 32'd0;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				if (emit) begin
					acc_q <= 32'd0;
					cnt_q <= 2'd0;
				end else begin
					acc_q <= acc_nxt;
					cnt_q <= cnt_q + 2'd1;
				end
			end
			if (push_en && emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && emit) begin
			out_q.reply_bytes  <= acc_nxt;
			out_q.valid_count  <= {1'b0, cnt_q} + 3'd1;
			out_q.is_exception <= exc;
			out_q.reply_last   <= push_fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= 17'd0;
			pos_q   <= 9'd0;
			tot_q   <= 9'd0;
			fc_q    <= 8'd0;
			pend_q  <= 8'd0;
			dbc_q   <= 8'd0;
			addr_q  <= 16'd0;
			qv_q    <= 16'd0;
			code_q  <= EXC_NONE;
			hidx_q  <= 3'd0;
			i_q     <= 11'd0;
			byte_q  <= 8'd0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 17'd1;
					if (clr_q == CLR_END) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						if (pos_q == 9'd0) fc_q <= in_data.pdu_byte;
						else if (pos_q == 9'd1 || pos_q == 9'd3) pend_q <= in_data.pdu_byte;
						else if (pos_q == 9'd2) addr_q <= {pend_q, in_data.pdu_byte};
						else if (pos_q == 9'd4) qv_q <= {pend_q, in_data.pdu_byte};
						else if (pos_q == 9'd5) dbc_q <= in_data.pdu_byte;
						else if (pos_q < POS_MAX && !p_jpos[0]) pend_q <= in_data.pdu_byte;
						if (in_data.last_byte) begin
							// Rewind the walk index so single writes address the start entry
							pos_q   <= 9'd0;
							tot_q   <= tot_nxt;
							i_q     <= 11'd0;
							state_q <= S_CHECK;
						end else begin
							pos_q <= tot_nxt;
						end
					end
				end
				S_CHECK: begin
					code_q <= code_c;
					hidx_q <= 3'd0;
					i_q    <= 11'd0;
					byte_q <= 8'd0;
					if (code_c == EXC_NONE && fc_q == FC_WRITE_COILS) state_q <= S_WC_REQ;
					else if (code_c == EXC_NONE && fc_q == FC_WRITE_REGS) state_q <= S_WW_REQ;
					else state_q <= S_HDR;
				end
				S_HDR: begin
					if (out_free) begin
						hidx_q <= hidx_q + 3'd1;
						if (hidx_q == hdr_last) begin
							if (exc || is_echo) state_q <= S_IDLE;
							else if (is_rd_bits) state_q <= S_RB_REQ;
							else state_q <= S_RW_REQ;
						end
					end
				end
				S_RB_REQ: state_q <= S_RB_BIT;
				S_RB_BIT: begin
					byte_q <= byte_q | ({7'b0, rb_bit} << i_q[2:0]);
					i_q    <= i_nxt[10:0];
					state_q <= (i_done || i_q[2:0] == 3'd7) ? S_RB_PUSH : S_RB_REQ;
				end
				S_RB_PUSH: begin
					if (out_free) begin
						byte_q  <= 8'd0;
						state_q <= push_fin ? S_IDLE : S_RB_REQ;
					end
				end
				S_RW_REQ: state_q <= S_RW_HI;
				S_RW_HI:  if (out_free) state_q <= S_RW_LO;
				S_RW_LO: begin
					if (out_free) begin
						i_q     <= i_nxt[10:0];
						state_q <= i_done ? S_IDLE : S_RW_REQ;
					end
				end
				S_WC_REQ: state_q <= S_WC_BIT;
				S_WC_BIT: begin
					i_q     <= i_nxt[10:0];
					state_q <= i_done ? S_HDR : S_WC_REQ;
				end
				S_WW_REQ: state_q <= S_WW_DATA;
				S_WW_DATA: begin
					i_q     <= i_nxt[10:0];
					state_q <= i_done ? S_HDR : S_WW_REQ;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Table write ports
	logic          coil_we, disc_we, hold_we, inp_we;
	logic [CW-1:0] coil_wa;
	logic [DW-1:0] disc_wa;
	logic [HW-1:0] hold_wa;
	logic [IW-1:0] inp_wa;
	logic          coil_wd, disc_wd;
	logic [15:0]   hold_wd, inp_wd;
	logic          commit_single;

	assign commit_single = (state_q == S_CHECK) && (code_c == EXC_NONE);

	always_comb begin
		coil_we = 1'b0;
		coil_wa = tbl_addr[CW-1:0];
		coil_wd = 1'b0;
		hold_we = 1'b0;
		hold_wa = tbl_addr[HW-1:0];
		hold_wd = 16'd0;
		disc_we = 1'b0;
		disc_wa = in_data.load_address[DW-1:0];
		disc_wd = in_data.load_value[0];
		inp_we  = 1'b0;
		inp_wa  = in_data.load_address[IW-1:0];
		inp_wd  = in_data.load_value;
		if (state_q == S_CLEAR) begin
			coil_we = (clr_q < COIL_N);
			coil_wa = clr_q[CW-1:0];
			hold_we = (clr_q < HOLD_N);
			hold_wa = clr_q[HW-1:0];
			disc_we = (clr_q < DISC_N);
			disc_wa = clr_q[DW-1:0];
			disc_wd = 1'b0;
			inp_we  = (clr_q < INPUT_N);
			inp_wa  = clr_q[IW-1:0];
			inp_wd  = 16'd0;
		end else begin
			if (commit_single && fc_q == FC_WRITE_COIL) begin
				coil_we = 1'b1;
				coil_wd = (qv_q == COIL_ON);
			end else if (state_q == S_WC_BIT) begin
				coil_we = 1'b1;
				coil_wd = wc_bit;
			end
			if (commit_single && fc_q == FC_WRITE_REG) begin
				hold_we = 1'b1;
				hold_wd = qv_q;
			end else if (state_q == S_WW_DATA) begin
				hold_we = 1'b1;
				hold_wd = stg_rd_q;
			end
			disc_we = in_acc && (in_data.opcode == OP_LOAD_DISC)
				&& ({1'b0, in_data.load_address} < DISC_N);
			inp_we  = in_acc && (in_data.opcode == OP_LOAD_IREG)
				&& ({1'b0, in_data.load_address} < INPUT_N);
		end
	end

	// Memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (coil_we) coil_mem[coil_wa] <= coil_wd;
		coil_rd_q <= coil_mem[tbl_addr[CW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		disc_rd_q <= disc_mem[tbl_addr[DW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hold_we) hold_mem[hold_wa] <= hold_wd;
		hold_rd_q <= hold_mem[tbl_addr[HW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (inp_we) inp_mem[inp_wa] <= inp_wd;
		inp_rd_q <= inp_mem[tbl_addr[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stg_we) stg_mem[stg_wa] <= stg_wdata;
		stg_rd_q <= stg_mem[stg_ridx[SW-1:0]];
	end

	// Every reply ends on a final byte, so the packer is empty between requests
	a_packer_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == 2'd0))
		else $error("packer holds bytes while idle");

	// No reply leaves during the table clearing pass
	a_no_out_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !out_valid_q)
		else $error("output valid during clearing pass");

	// Table walks stay below the requested quantity
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RB_BIT || state_q == S_RW_LO || state_q == S_WC_BIT
			|| state_q == S_WW_DATA) |-> (i_ext < {1'b0, qv_q}))
		else $error("table walk past quantity");

	// A request byte with the last flag always starts the checks
	a_last_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		last_acc |=> (state_q == S_CHECK))
		else $error("last byte did not start serving");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import mbpdu_pkg::*;

	localparam int TABLE_SIZE  = 1024;
	localparam int STAGE_SLOTS = 128;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	int idle_pct  = 19;
	int stall_pct = 19;
	int req_bytes = 0;

	// Predicts reply transactions of the PDU server and compares them in order
	class pdu_scoreboard;
		int lim_rbits, lim_rwords, lim_wbits, lim_wwords;
		int pos, fcode, saddr, qval, dcount, hi_byte;
		logic [15:0] staged[STAGE_SLOTS];
		bit          coils[TABLE_SIZE];
		bit          discs[TABLE_SIZE];
		logic [15:0] holds[TABLE_SIZE];
		logic [15:0] iregs[TABLE_SIZE];
		logic [7:0]  rsp[$];
		out_item_t   replies_due[$];
		int          errors;

		function void clear();
			lim_rbits = LIM_READ_BITS; lim_rwords = LIM_READ_WORDS;
			lim_wbits = LIM_WRITE_BITS; lim_wwords = LIM_WRITE_WORDS;
			pos = 0; fcode = 0; saddr = 0; qval = 0; dcount = 0; hi_byte = 0;
			errors = 0;
			foreach (staged[i]) staged[i] = '0;
			foreach (coils[i]) begin
				coils[i] = 0; discs[i] = 0; holds[i] = '0; iregs[i] = '0;
			end
		endfunction

		function void set_limit(logic [1:0] idx, logic [10:0] val);
			case (idx)
				CFG_MAX_READ_BITS:   lim_rbits = val;
				CFG_MAX_READ_WORDS:  lim_rwords = val[6:0];
				CFG_MAX_WRITE_BITS:  lim_wbits = val;
				default:             lim_wwords = val[6:0];
			endcase
		endfunction

		function int clampv(int v, int hi);
			return v > hi ? hi : v;
		endfunction

		function logic [7:0] data_at(int j, int received);
			if ((j % 2) == 0 && j + 1 == received) return hi_byte[7:0];
			if ((j >> 1) >= STAGE_SLOTS) return 8'h00;
			return (j % 2) ? staged[j >> 1][7:0] : staged[j >> 1][15:8];
		endfunction

		// Split the reply into four-byte transactions
		function void emit(bit exc);
			int n;
			out_item_t r;
			n = (rsp.size() + 3) / 4;
			for (int k = 0; k < n; k++) begin
				r = '0;
				for (int i = 0; i < 4; i++) begin
					r.reply_bytes = r.reply_bytes << 8;
					if (k * 4 + i < rsp.size()) begin
						r.reply_bytes[7:0] = rsp[k * 4 + i];
						r.valid_count++;
					end
				end
				r.is_exception = exc;
				r.reply_last = (k + 1 == n);
				replies_due.push_back(r);
			end
		endfunction

		function void fail(logic [7:0] code);
			rsp = '{fcode[7:0] | EXC_FLAG, code};
			emit(1);
		endfunction

		function void echo();
			rsp = '{fcode[7:0], saddr[15:8], saddr[7:0], qval[15:8], qval[7:0]};
			emit(0);
		endfunction

		function void serve(int total);
			int received, need;
			bit multi;
			logic [7:0] b;
			received = total > DATA_OFFSET ? total - DATA_OFFSET : 0;
			multi = (fcode == FC_WRITE_COILS || fcode == FC_WRITE_REGS);
			if (!(fcode >= FC_READ_COILS && fcode <= FC_WRITE_REG) && !multi) begin
				fail(EXC_ILLEGAL_FC);
				return;
			end
			if (total - 1 < (multi ? 5 : 4)) begin
				fail(EXC_BAD_VALUE);
				return;
			end
			case (fcode[7:0])
				FC_READ_COILS, FC_READ_DISC: begin
					need = (qval + 7) / 8;
					if (qval == 0 || qval > clampv(lim_rbits, LIM_READ_BITS)) fail(EXC_BAD_VALUE);
					else if (saddr + qval > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						rsp = '{fcode[7:0], need[7:0]};
						for (int i = 0; i < need; i++) begin
							b = '0;
							for (int k = 0; k < 8 && i * 8 + k < qval; k++)
								b[k] = (fcode == FC_READ_COILS) ? coils[saddr + i * 8 + k]
									: discs[saddr + i * 8 + k];
							rsp.push_back(b);
						end
						emit(0);
					end
				end
				FC_READ_HOLD, FC_READ_INPUT: begin
					if (qval == 0 || qval > clampv(lim_rwords, LIM_READ_WORDS)) fail(EXC_BAD_VALUE);
					else if (saddr + qval > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						need = qval * 2;
						rsp = '{fcode[7:0], need[7:0]};
						for (int i = 0; i < qval; i++) begin
							if (fcode == FC_READ_HOLD) begin
								rsp.push_back(holds[saddr + i][15:8]);
								rsp.push_back(holds[saddr + i][7:0]);
							end else begin
								rsp.push_back(iregs[saddr + i][15:8]);
								rsp.push_back(iregs[saddr + i][7:0]);
							end
						end
						emit(0);
					end
				end
				FC_WRITE_COIL: begin
					if (qval != COIL_OFF && qval != COIL_ON) fail(EXC_BAD_VALUE);
					else if (saddr + 1 > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						coils[saddr] = (qval == COIL_ON);
						echo();
					end
				end
				FC_WRITE_REG: begin
					if (saddr + 1 > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						holds[saddr] = qval[15:0];
						echo();
					end
				end
				FC_WRITE_COILS: begin
					need = (qval + 7) / 8;
					if (qval == 0 || qval > clampv(lim_wbits, LIM_WRITE_BITS)) fail(EXC_BAD_VALUE);
					else if (dcount != (need & 8'hFF)) fail(EXC_BAD_VALUE);
					else if (received < need) fail(EXC_BAD_VALUE);
					else if (saddr + qval > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						for (int i = 0; i < qval; i++) begin
							b = data_at(i >> 3, received);
							coils[saddr + i] = b[i % 8];
						end
						echo();
					end
				end
				default: begin
					need = qval * 2;
					if (qval == 0 || qval > clampv(lim_wwords, LIM_WRITE_WORDS)) fail(EXC_BAD_VALUE);
					else if (dcount != (need & 8'hFF)) fail(EXC_BAD_VALUE);
					else if (received < need) fail(EXC_BAD_VALUE);
					else if (saddr + qval > TABLE_SIZE) fail(EXC_BAD_ADDR);
					else begin
						for (int i = 0; i < qval; i++)
							holds[saddr + i] = {data_at(2 * i, received),
								data_at(2 * i + 1, received)};
						echo();
					end
				end
			endcase
		endfunction

		// Advance the request state on an accepted input transaction
		function void note_input(in_item_t it);
			int j;
			case (it.opcode)
				OP_LOAD_IREG: if (it.load_address < TABLE_SIZE) iregs[it.load_address] = it.load_value;
				OP_LOAD_DISC: if (it.load_address < TABLE_SIZE) discs[it.load_address] = it.load_value[0];
				OP_REQ_BYTE: begin
					if (pos == 0) fcode = it.pdu_byte;
					else if (pos == 1 || pos == 3) hi_byte = it.pdu_byte;
					else if (pos == 2) saddr = (hi_byte << 8) | it.pdu_byte;
					else if (pos == 4) qval = (hi_byte << 8) | it.pdu_byte;
					else if (pos == 5) dcount = it.pdu_byte;
					else if (pos < POS_MAX) begin
						j = pos - DATA_OFFSET;
						if ((j % 2) == 0) hi_byte = it.pdu_byte;
						else if ((j >> 1) < STAGE_SLOTS)
							staged[j >> 1] = {hi_byte[7:0], it.pdu_byte};
					end
					pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
					if (it.last_byte) begin
						serve(pos);
						pos = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.reply_bytes !== want.reply_bytes) begin
				$display("%0t: reply_bytes: expected %h, actual %h", $time,
					want.reply_bytes, got.reply_bytes);
				errors++;
			end
			if (got.valid_count !== want.valid_count) begin
				$display("%0t: valid_count: expected %0d, actual %0d", $time,
					want.valid_count, got.valid_count);
				errors++;
			end
			if (got.is_exception !== want.is_exception) begin
				$display("%0t: is_exception: expected %b, actual %b", $time,
					want.is_exception, got.is_exception);
				errors++;
			end
			if (got.reply_last !== want.reply_last) begin
				$display("%0t: reply_last: expected %b, actual %b", $time,
					want.reply_last, got.reply_last);
				errors++;
			end
		endfunction
	endclass

	pdu_scoreboard sb = new();

	modbus_pdu_server_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Stall the reply side at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check every accepted reply transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// Drive one transaction and hold it until accepted
	task automatic push(in_item_t it);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_data <= it;
				break;
			end
		end
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(it);
		if (it.opcode == OP_REQ_BYTE) req_bytes++;
	endtask

	task automatic push_load();
		in_item_t it;
		it.opcode = $urandom_range(1, 3);
		it.pdu_byte = $urandom_range(255);
		it.last_byte = $urandom_range(1);
		it.load_address = ($urandom_range(99) < 80) ? $urandom_range(TABLE_SIZE - 1)
			: $urandom_range(65535);
		it.load_value = $urandom_range(65535);
		push(it);
	endtask

	// Send a request PDU, with loads mixed in now and then
	task automatic send_pdu(logic [7:0] pdu[$]);
		in_item_t it;
		foreach (pdu[i]) begin
			if ($urandom_range(99) < 8) push_load();
			it.opcode = OP_REQ_BYTE;
			it.pdu_byte = pdu[i];
			it.last_byte = (i == pdu.size() - 1);
			it.load_address = $urandom_range(65535);
			it.load_value = $urandom_range(65535);
			push(it);
		end
	endtask

	// Drop the input, then let the block drain before touching configuration
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.replies_due.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [1:0] idx, logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(idx, val);
	endtask

	task automatic set_limits(int rb, int rw, int wb, int ww);
		wait_drained();
		write_limit(CFG_MAX_READ_BITS, rb);
		write_limit(CFG_MAX_READ_WORDS, rw);
		write_limit(CFG_MAX_WRITE_BITS, wb);
		write_limit(CFG_MAX_WRITE_WORDS, ww);
	endtask

	function automatic int pick_count(int typical, int full);
		int r;
		r = $urandom_range(99);
		if (r < 85) return $urandom_range(1, typical);
		if (r < 90) return $urandom_range(typical, full);
		if (r < 94) return 0;
		if (r < 97) return full + $urandom_range(1, 20);
		return $urandom_range(65535);
	endfunction

	// Build a mostly well-formed request with random content
	task automatic random_request();
		logic [7:0] fcs[8] = '{FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT,
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};
		logic [7:0] pdu[$];
		logic [7:0] fc;
		int a, q, need, r, ndata, cut;
		fc = ($urandom_range(99) < 90) ? fcs[$urandom_range(7)] : $urandom_range(255);
		r = $urandom_range(99);
		if (r < 60) a = $urandom_range(200);
		else if (r < 90) a = TABLE_SIZE - $urandom_range(1, 40);
		else a = $urandom_range(65535);
		case (fc)
			FC_READ_COILS, FC_READ_DISC: q = pick_count(40, LIM_READ_BITS);
			FC_READ_HOLD, FC_READ_INPUT: q = pick_count(10, LIM_READ_WORDS);
			FC_WRITE_COIL: begin
				r = $urandom_range(99);
				q = (r < 80) ? ((r % 2) ? COIL_ON : COIL_OFF) : $urandom_range(65535);
			end
			FC_WRITE_COILS: q = ($urandom_range(99) < 96) ? pick_count(40, 300)
				: $urandom_range(1, LIM_WRITE_BITS);
			FC_WRITE_REGS: q = pick_count(8, LIM_WRITE_WORDS);
			default: q = $urandom_range(65535);
		endcase
		pdu = '{fc, a[15:8], a[7:0], q[15:8], q[7:0]};
		if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
			need = (fc == FC_WRITE_COILS) ? (q + 7) / 8 : q * 2;
			if (need > 250) need = 250;
			pdu.push_back(($urandom_range(99) < 90) ? need : $urandom_range(255));
			ndata = ($urandom_range(99) < 90) ? need : $urandom_range(need + 3);
			repeat (ndata) pdu.push_back($urandom_range(255));
		end
		r = $urandom_range(99);
		if (r < 5) begin
			cut = $urandom_range(1, pdu.size());
			while (pdu.size() > cut) void'(pdu.pop_back());
		end else if (r < 10) begin
			repeat ($urandom_range(1, 3)) pdu.push_back($urandom_range(255));
		end
		send_pdu(pdu);
	endtask

	task automatic run_random(int target);
		while (req_bytes < target) random_request();
	endtask

	initial begin
		in_item_t it;
		sb.clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		do @(posedge clk); while (in_stall);

		// Directed: loads at the table edges, ignored loads, every function code
		it = '{OP_LOAD_IREG, 8'hFF, 1'b1, 16'd1023, 16'hFFFF};
		push(it);
		it = '{OP_LOAD_DISC, 8'h00, 1'b0, 16'd1023, 16'hFFFF};
		push(it);
		it = '{OP_LOAD_IREG, 8'h00, 1'b0, 16'hFFFF, 16'h1234};
		push(it);
		it = '{2'd3, 8'h00, 1'b1, 16'd5, 16'h5555};
		push(it);
		send_pdu('{8'h07});
		send_pdu('{FC_READ_HOLD, 8'h00, 8'h00, 8'h00});
		send_pdu('{FC_READ_COILS, 8'h03, 8'hF8, 8'h00, 8'h08});
		send_pdu('{FC_READ_DISC, 8'h03, 8'hF8, 8'h00, 8'h08});
		send_pdu('{FC_READ_INPUT, 8'h03, 8'hFF, 8'h00, 8'h01});
		send_pdu('{FC_READ_INPUT, 8'h03, 8'hFF, 8'h00, 8'h02});
		send_pdu('{FC_WRITE_COIL, 8'h00, 8'h03, 8'hFF, 8'h00});
		send_pdu('{FC_WRITE_COIL, 8'h00, 8'h03, 8'h12, 8'h34});
		send_pdu('{FC_WRITE_REG, 8'h03, 8'hFF, 8'hAB, 8'hCD});
		send_pdu('{FC_WRITE_REG, 8'h04, 8'h00, 8'hAB, 8'hCD});
		send_pdu('{FC_WRITE_COILS, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h02, 8'hA5, 8'h03});
		send_pdu('{FC_WRITE_REGS, 8'h00, 8'h05, 8'h00, 8'h02, 8'h04,
			8'h80, 8'h01, 8'hFF, 8'hFE, 8'h77});
		send_pdu('{FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'd125});
		send_pdu('{FC_READ_COILS, 8'h00, 8'h00, 8'h07, 8'hD0});

		// Random phases across limit settings
		run_random(req_bytes + 20);
		set_limits(2047, 127, 2047, 127);
		run_random(req_bytes + 15);
		set_limits(0, 0, 0, 0);
		run_random(req_bytes + 10);
		set_limits(1, 1, 1, 1);
		run_random(req_bytes + 10);
		idle_pct = 0;
		stall_pct = 0;
		set_limits(16, 8, 16, 8);
		run_random(req_bytes + 20);
		idle_pct = 19;
		stall_pct = 19;
		set_limits($urandom_range(2047), $urandom_range(127),
			$urandom_range(2047), $urandom_range(127));
		run_random(req_bytes + 15);
		set_limits(LIM_READ_BITS, LIM_READ_WORDS, LIM_WRITE_BITS, LIM_WRITE_WORDS);
		run_random(req_bytes + 15);

		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.replies_due.size() != 0);
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.replies_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
